// ----- sv/east_pkg.sv -----
`timescale 1ns / 1ps

package east_pkg;

   // field widths
   localparam int ACTION_W   = 2;
   localparam int COUNT_W    = 16;
   localparam int RAW_W      = 32;
   localparam int ANGLE_W    = 64;
   localparam int SPEED_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // datapath widths
   localparam int STEP_W     = 19;
   localparam int POS_PROD_W = STEP_W + 33;
   localparam int SPD_PROD_W = RAW_W + 33;

   // dividend bits retired per divider stage
   localparam int DIV_STEP = 4;

   // transaction kinds
   localparam logic [ACTION_W-1:0] ACTION_POSITION = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_SPEED    = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_TICK     = 2'd2;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_PER_STEP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_MAX      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_MIN      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE        = 3'd5;

   // register reset values
   localparam logic [31:0]                APS_RESET     = 32'd1686629713;
   localparam logic [31:0]                GAIN_RESET    = 32'd65536;
   localparam logic [31:0]                TIMEOUT_RESET = 32'd1000;
   localparam logic signed [COUNT_W-1:0]  CMAX_RESET    = 16'sh7FFF;
   localparam logic signed [COUNT_W-1:0]  CMIN_RESET    = 16'sh8000;

   // speed saturation limits
   localparam logic signed [SPEED_W-1:0] SPEED_MAX = 32'sh7FFFFFFF;
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = 32'sh80000000;

   // result fields that ride alongside the mean through the divider
   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic signed [SPEED_W-1:0] speed;
      logic                      alive;
   } side_type;

endpackage

// ----- sv/east_req_if.sv -----
`timescale 1ns / 1ps

interface east_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [15:0] position_count;
   logic signed [31:0] speed_count;

   modport source (output valid, action, position_count, speed_count, input ready);
   modport sink   (input valid, action, position_count, speed_count, output ready);
endinterface

// ----- sv/east_rsp_if.sv -----
`timescale 1ns / 1ps

interface east_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] angle;
   logic signed [31:0] speed;
   logic signed [31:0] filtered_speed;
   logic               alive;

   modport source (output valid, angle, speed, filtered_speed, alive, input ready);
   modport sink   (input valid, angle, speed, filtered_speed, alive, output ready);
endinterface

// ----- sv/east_csr_if.sv -----
`timescale 1ns / 1ps

interface east_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/east_ram.sv -----
`timescale 1ns / 1ps

module east_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 10
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/east_mean_div.sv -----
`timescale 1ns / 1ps

module east_mean_div import east_pkg::*; #(
   parameter int SUM_W  = 37,
   parameter int FILL_W = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  side_type                 in_side,
   input  logic signed [SUM_W-1:0]  in_sum,
   input  logic [FILL_W-1:0]        in_fill,
   output logic                     out_valid,
   input  logic                     out_ready,
   output side_type                 out_side,
   output logic signed [SPEED_W-1:0] out_mean
);

   localparam int STAGES = (SUM_W + DIV_STEP - 1) / DIV_STEP;
   localparam int QW     = STAGES * DIV_STEP;

   // stage 0 latches the transaction, stages 1..STAGES each retire DIV_STEP bits
   logic              vld_ff  [0:STAGES];
   side_type          side_ff [0:STAGES];
   logic              neg_ff  [0:STAGES];
   logic [FILL_W-1:0] dvs_ff  [0:STAGES];
   logic [FILL_W-1:0] rem_ff  [0:STAGES];
   logic [QW-1:0]     quo_ff  [0:STAGES];
   logic [FILL_W-1:0] rem_in  [1:STAGES];
   logic [QW-1:0]     quo_in  [1:STAGES];
   logic              rdy     [0:STAGES];

   logic                      out_valid_ff;
   side_type                  out_side_ff;
   logic signed [SPEED_W-1:0] out_mean_ff;
   logic signed [SPEED_W-1:0] out_mean_in;
   logic [SPEED_W-1:0]        quo_low;
   logic                      out_free;

   // ready chain, a stage moves when it is empty or its successor moves
   assign out_free = !out_valid_ff || out_ready;

   always_comb begin
      rdy[STAGES] = !vld_ff[STAGES] || out_free;
      for (int k = STAGES - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k + 1];
      end
   end

   assign in_ready = rdy[0];

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         side_ff[0] <= in_side;
         neg_ff[0]  <= in_sum[SUM_W-1];
         dvs_ff[0]  <= in_fill;
         rem_ff[0]  <= '0;
         quo_ff[0]  <= QW'(in_sum);
      end
   end

   // restoring division stages
   for (genvar k = 1; k <= STAGES; k++) begin : g_stage
      always_comb begin
         logic [FILL_W-1:0] rem;
         logic [QW-1:0]     quo;
         logic [FILL_W:0]   shifted;
         rem = rem_ff[k - 1];
         quo = quo_ff[k - 1];
         // first stage turns the signed sum into its magnitude
         if (k == 1) begin
            if (neg_ff[k - 1]) begin
               quo = -quo;
            end
         end
         for (int j = 0; j < DIV_STEP; j++) begin
            shifted = {rem, quo[QW-1]};
            quo     = {quo[QW-2:0], 1'b0};
            if (shifted >= {1'b0, dvs_ff[k - 1]}) begin
               shifted = shifted - {1'b0, dvs_ff[k - 1]};
               quo[0]  = 1'b1;
            end
            rem = shifted[FILL_W-1:0];
         end
         rem_in[k] = rem;
         quo_in[k] = quo;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= vld_ff[k - 1];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            side_ff[k] <= side_ff[k - 1];
            neg_ff[k]  <= neg_ff[k - 1];
            dvs_ff[k]  <= dvs_ff[k - 1];
            rem_ff[k]  <= rem_in[k];
            quo_ff[k]  <= quo_in[k];
         end
      end
   end

   // sign fix-up, empty window and dead encoder read as zero
   assign quo_low = quo_ff[STAGES][SPEED_W-1:0];

   always_comb begin
      if (!side_ff[STAGES].alive || dvs_ff[STAGES] == '0) begin
         out_mean_in = '0;
      end else if (neg_ff[STAGES]) begin
         out_mean_in = signed'(-quo_low);
      end else begin
         out_mean_in = signed'(quo_low);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= vld_ff[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_side_ff <= side_ff[STAGES];
         out_mean_ff <= out_mean_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_side  = out_side_ff;
   assign out_mean  = out_mean_ff;

endmodule

// ----- sv/encoder_angle_speed_tracker.sv -----
`timescale 1ns / 1ps
// from acceptance to result valid: input register, product stage, then the pipelined mean
// divider's input stage, its division stages and its result register
// throughput: one transaction per cycle; stalls only when every stage holds a result
// reset (synchronous): registers take their default values, the encoder is dead,
// the angle, speed and window are cleared; window storage needs no clearing pass

module encoder_angle_speed_tracker import east_pkg::*; #(
   parameter int WINDOW_LEN = 10
) (
   input logic         clock,
   input logic         reset,
   east_csr_if.sink    csr_bus,
   east_req_if.sink    req_bus,
   east_rsp_if.source  rsp_bus
);

   localparam int FILL_W = $clog2(WINDOW_LEN + 1);
   localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int SUM_W  = 33 + $clog2(WINDOW_LEN);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LEN);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

   // configuration registers
   logic [31:0]                aps_ff;
   logic [31:0]                gain_ff;
   logic [31:0]                timeout_ff;
   logic signed [COUNT_W-1:0]  cmax_ff;
   logic signed [COUNT_W-1:0]  cmin_ff;
   logic                       reverse_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         aps_ff     <= APS_RESET;
         gain_ff    <= GAIN_RESET;
         timeout_ff <= TIMEOUT_RESET;
         cmax_ff    <= CMAX_RESET;
         cmin_ff    <= CMIN_RESET;
         reverse_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_ANGLE_PER_STEP: aps_ff     <= csr_bus.data;
            CSR_SPEED_GAIN:     gain_ff    <= csr_bus.data;
            CSR_TIMEOUT_TICKS:  timeout_ff <= csr_bus.data;
            CSR_COUNT_MAX:      cmax_ff    <= signed'(csr_bus.data[COUNT_W-1:0]);
            CSR_COUNT_MIN:      cmin_ff    <= signed'(csr_bus.data[COUNT_W-1:0]);
            CSR_REVERSE:        reverse_ff <= csr_bus.data[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // front state: liveness, reference count and idle time, updated on accept
   // ------------------------------------------------------------------
   logic                      alive_ff, alive_in;
   logic signed [COUNT_W-1:0] last_ff, last_in;
   logic [31:0]               idle_ff, idle_in;
   logic [31:0]               idle_inc;
   logic                      req_fire;
   logic                      acc_pos, acc_spd, acc_clr;
   logic signed [STEP_W-1:0]  acc_steps;

   logic                      s1_valid_ff;
   logic                      s1_ready;
   logic                      s1_pos_ff, s1_spd_ff, s1_clr_ff, s1_alive_ff;
   logic signed [STEP_W-1:0]  s1_steps_ff;
   logic signed [RAW_W-1:0]   s1_raw_ff;

   assign req_bus.ready = s1_ready;
   assign req_fire      = req_bus.valid && s1_ready;
   assign idle_inc      = (idle_ff == '1) ? idle_ff : idle_ff + 32'd1;

   // wrap-corrected step count and next front state
   always_comb begin
      logic signed [COUNT_W:0]  dbl_last;
      logic signed [COUNT_W:0]  dbl_now;
      logic signed [COUNT_W:0]  cmax_x;
      logic signed [COUNT_W:0]  cmin_x;
      logic signed [STEP_W-1:0] span;
      logic signed [STEP_W-1:0] steps;
      dbl_last = {last_ff, 1'b0};
      dbl_now  = {req_bus.position_count, 1'b0};
      cmax_x   = (COUNT_W + 1)'(cmax_ff);
      cmin_x   = (COUNT_W + 1)'(cmin_ff);
      span     = STEP_W'(cmax_ff) - STEP_W'(cmin_ff);
      steps    = STEP_W'(req_bus.position_count) - STEP_W'(last_ff);
      if (dbl_last > cmax_x && dbl_now < cmin_x) begin
         steps = steps + span;
      end
      if (dbl_last < cmin_x && dbl_now > cmax_x) begin
         steps = steps - span;
      end
      if (reverse_ff) begin
         steps = -steps;
      end
      acc_steps = steps;

      alive_in = alive_ff;
      last_in  = last_ff;
      idle_in  = idle_ff;
      acc_pos  = 1'b0;
      acc_spd  = 1'b0;
      acc_clr  = 1'b0;
      case (req_bus.action)
         ACTION_POSITION: begin
            // first position after reset or timeout only takes the reference
            acc_pos  = alive_ff;
            alive_in = 1'b1;
            last_in  = req_bus.position_count;
         end
         ACTION_SPEED: begin
            acc_spd = 1'b1;
            idle_in = '0;
         end
         ACTION_TICK: begin
            idle_in = idle_inc;
            if (idle_inc > timeout_ff) begin
               alive_in = 1'b0;
               acc_clr  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= 1'b0;
         last_ff  <= '0;
         idle_ff  <= '0;
      end else if (req_fire) begin
         alive_ff <= alive_in;
         last_ff  <= last_in;
         idle_ff  <= idle_in;
      end
   end

   // input register
   logic s2_valid_ff;
   logic s2_ready;

   assign s1_ready = !s1_valid_ff || s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_pos_ff   <= acc_pos;
         s1_spd_ff   <= acc_spd;
         s1_clr_ff   <= acc_clr;
         s1_alive_ff <= alive_in;
         s1_steps_ff <= acc_steps;
         s1_raw_ff   <= req_bus.speed_count;
      end
   end

   // ------------------------------------------------------------------
   // product stage: angle increment and scaled speed
   // ------------------------------------------------------------------
   logic                         s2_pos_ff, s2_spd_ff, s2_clr_ff, s2_alive_ff;
   logic signed [POS_PROD_W-1:0] s2_pos_prod_ff;
   logic signed [SPD_PROD_W-1:0] s2_spd_prod_ff;
   logic                         div_in_ready;
   logic                         div_fire;

   assign s2_ready = !s2_valid_ff || div_in_ready;
   assign div_fire = s2_valid_ff && div_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_pos_ff      <= s1_pos_ff;
         s2_spd_ff      <= s1_spd_ff;
         s2_clr_ff      <= s1_clr_ff;
         s2_alive_ff    <= s1_alive_ff;
         s2_pos_prod_ff <= POS_PROD_W'(s1_steps_ff) * POS_PROD_W'(signed'({1'b0, aps_ff}));
         s2_spd_prod_ff <= SPD_PROD_W'(s1_raw_ff) * SPD_PROD_W'(signed'({1'b0, gain_ff}));
      end
   end

   // ------------------------------------------------------------------
   // accumulate stage: angle, saturated speed and rolling window
   // ------------------------------------------------------------------
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;
   logic signed [SPEED_W-1:0] latest_ff, latest_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic signed [SPEED_W-1:0] spd_sat;
   logic signed [SPEED_W-1:0] evict;
   logic [SPEED_W-1:0]        ram_rd_data;
   logic                      ram_wr_en;
   logic [SLOT_W-1:0]         ram_rd_addr;
   logic                      byp_ff;
   logic signed [SPEED_W-1:0] byp_data_ff;
   logic [SPD_PROD_W-SPEED_W:0] spd_hi;
   side_type                  div_side;

   // saturate the Q16.16 product to 32 bits
   assign spd_hi = s2_spd_prod_ff[SPD_PROD_W-1:SPEED_W-1];

   always_comb begin
      if (&spd_hi || ~|spd_hi) begin
         spd_sat = s2_spd_prod_ff[SPEED_W-1:0];
      end else if (s2_spd_prod_ff[SPD_PROD_W-1]) begin
         spd_sat = SPEED_MIN;
      end else begin
         spd_sat = SPEED_MAX;
      end
   end

   // oldest sample, forwarded when the last write hit the slot being read
   assign evict = byp_ff ? byp_data_ff : signed'(ram_rd_data);

   always_comb begin
      angle_in  = s2_pos_ff ? angle_ff + ANGLE_W'(s2_pos_prod_ff) : angle_ff;
      latest_in = latest_ff;
      sum_in    = sum_ff;
      fill_in   = fill_ff;
      slot_in   = slot_ff;
      if (s2_clr_ff) begin
         latest_in = '0;
         sum_in    = '0;
         fill_in   = '0;
         slot_in   = '0;
      end else if (s2_spd_ff) begin
         latest_in = spd_sat;
         if (fill_ff == FILL_FULL) begin
            sum_in = sum_ff - SUM_W'(evict) + SUM_W'(spd_sat);
         end else begin
            sum_in  = sum_ff + SUM_W'(spd_sat);
            fill_in = fill_ff + 1'b1;
         end
         slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff  <= '0;
         latest_ff <= '0;
         sum_ff    <= '0;
         fill_ff   <= '0;
         slot_ff   <= '0;
      end else if (div_fire) begin
         angle_ff  <= angle_in;
         latest_ff <= latest_in;
         sum_ff    <= sum_in;
         fill_ff   <= fill_in;
         slot_ff   <= slot_in;
      end
   end

   // window storage, read one slot ahead of the next write
   assign ram_wr_en   = div_fire && s2_spd_ff && !s2_clr_ff;
   assign ram_rd_addr = div_fire ? slot_in : slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= ram_wr_en && (slot_ff == ram_rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= spd_sat;
   end

   east_ram #(
      .WIDTH (SPEED_W),
      .DEPTH (WINDOW_LEN)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (spd_sat),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // rolling mean and result register
   // ------------------------------------------------------------------
   side_type                  rsp_side;
   logic signed [SPEED_W-1:0] rsp_mean;

   always_comb begin
      div_side.angle = angle_in;
      div_side.speed = s2_alive_ff ? latest_in : '0;
      div_side.alive = s2_alive_ff;
   end

   east_mean_div #(
      .SUM_W  (SUM_W),
      .FILL_W (FILL_W)
   ) u_mean_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_ready  (div_in_ready),
      .in_side   (div_side),
      .in_sum    (sum_in),
      .in_fill   (fill_in),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_side  (rsp_side),
      .out_mean  (rsp_mean)
   );

   assign rsp_bus.angle          = rsp_side.angle;
   assign rsp_bus.speed          = rsp_side.speed;
   assign rsp_bus.filtered_speed = rsp_mean;
   assign rsp_bus.alive          = rsp_side.alive;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   a_timeout_kills: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus.action == ACTION_TICK && idle_inc > timeout_ff |=> !alive_ff)
      else $error("timeout tick left the encoder alive");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      div_fire && s2_clr_ff |=> fill_ff == '0 && sum_ff == '0 && latest_ff == '0)
      else $error("window not emptied on timeout");

   a_full_stays_full: assert property (@(posedge clock) disable iff (reset)
      div_fire && s2_spd_ff && fill_ff == FILL_FULL |=> fill_ff == FILL_FULL)
      else $error("full window lost a sample");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> slot_ff <= SLOT_LAST && fill_ff <= FILL_FULL)
      else $error("window write outside the window");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import east_pkg::*;

   localparam int WINDOW_LEN   = 10;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 30;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 228;
   localparam int REPORT_CAP   = 200;

   // action code the block leaves unused
   localparam logic [ACTION_W-1:0] ACTION_NONE = 2'd3;
   // register indexes past the end of the map
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct {
      logic signed [ANGLE_W-1:0] angle;
      logic signed [SPEED_W-1:0] speed;
      logic signed [SPEED_W-1:0] filtered_speed;
      logic                      alive;
   } tracker_result_t;

   // angle and speed tracking, bit exact, plus the results still owed by the block
   class angle_speed_predictor;
      bit [31:0]             angle_per_step;
      bit [31:0]             speed_gain;
      bit [31:0]             timeout_ticks;
      bit signed [15:0]      count_max;
      bit signed [15:0]      count_min;
      bit                    reverse;

      bit signed [15:0]      last_count;
      bit                    alive;
      bit [63:0]             angle_acc;
      bit signed [31:0]      speed_latest;
      bit signed [31:0]      window[WINDOW_LEN];
      longint                window_sum;
      int                    window_fill;
      int                    window_slot;
      bit [31:0]             idle_ticks;

      tracker_result_t       due_results[$];
      int                    errors;
      int                    reports;

      function new();
         angle_per_step = APS_RESET;
         speed_gain     = GAIN_RESET;
         timeout_ticks  = TIMEOUT_RESET;
         count_max      = CMAX_RESET;
         count_min      = CMIN_RESET;
         reverse        = 1'b0;
         last_count     = '0;
         alive          = 1'b0;
         angle_acc      = '0;
         speed_latest   = '0;
         idle_ticks     = '0;
         errors         = 0;
         reports        = 0;
         clear_window();
      endfunction

      function void clear_window();
         foreach (window[i]) window[i] = '0;
         window_sum  = 0;
         window_fill = 0;
         window_slot = 0;
      endfunction

      function void apply_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_ANGLE_PER_STEP: angle_per_step = data;
            CSR_SPEED_GAIN:     speed_gain     = data;
            CSR_TIMEOUT_TICKS:  timeout_ticks  = data;
            CSR_COUNT_MAX:      count_max      = data[15:0];
            CSR_COUNT_MIN:      count_min      = data[15:0];
            CSR_REVERSE:        reverse        = data[0];
            default: ;
         endcase
      endfunction

      // advance the tracker by one accepted transaction and queue what it should report
      function void add_request(logic [ACTION_W-1:0] action, logic signed [COUNT_W-1:0] pos,
                                logic signed [RAW_W-1:0] raw);
         longint          steps, span, prev, now, cmax, cmin, gained, mean;
         tracker_result_t res;
         case (action)
            ACTION_POSITION: begin
               if (!alive) begin
                  // first position only takes the reference count
                  last_count = pos;
                  alive      = 1'b1;
               end else begin
                  prev  = last_count;
                  now   = pos;
                  cmax  = count_max;
                  cmin  = count_min;
                  steps = now - prev;
                  span  = cmax - cmin;
                  // counter wrap in either direction, both tests on doubled counts against the limits
                  if (2 * prev > cmax && 2 * now < cmin) steps += span;
                  if (2 * prev < cmin && 2 * now > cmax) steps -= span;
                  if (reverse) steps = -steps;
                  angle_acc  += steps * longint'({32'd0, angle_per_step});
                  last_count  = pos;
               end
            end
            ACTION_SPEED: begin
               gained = longint'(raw) * longint'({32'd0, speed_gain});
               if (gained > longint'(SPEED_MAX)) gained = SPEED_MAX;
               else if (gained < longint'(SPEED_MIN)) gained = SPEED_MIN;
               speed_latest = gained[31:0];
               // rolling window, oldest sample drops out once full
               if (window_fill >= WINDOW_LEN) window_sum -= window[window_slot];
               else window_fill++;
               window[window_slot] = speed_latest;
               window_sum += speed_latest;
               window_slot = (window_slot + 1) % WINDOW_LEN;
               idle_ticks  = '0;
            end
            ACTION_TICK: begin
               if (idle_ticks != 32'hFFFF_FFFF) idle_ticks++;
               if (idle_ticks > timeout_ticks) begin
                  alive        = 1'b0;
                  speed_latest = '0;
                  clear_window();
               end
            end
            default: ;
         endcase

         mean = 0;
         if (window_fill > 0) mean = window_sum / window_fill;
         res.angle          = angle_acc;
         res.speed          = alive ? speed_latest : '0;
         res.filtered_speed = alive ? mean[31:0] : '0;
         res.alive          = alive;
         due_results.push_back(res);
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            errors++;
            if (reports < REPORT_CAP)
               $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            reports++;
         end
      endfunction

      function void check_response(tracker_result_t got);
         tracker_result_t want;
         if (due_results.size() == 0) begin
            errors++;
            if (reports < REPORT_CAP)
               $display("%0t: unexpected result, angle %h speed %h filtered %h alive %b",
                        $time, got.angle, got.speed, got.filtered_speed, got.alive);
            reports++;
            return;
         end
         want = due_results.pop_front();
         compare_field("angle", want.angle, got.angle);
         compare_field("speed", want.speed, got.speed);
         compare_field("filtered_speed", want.filtered_speed, got.filtered_speed);
         compare_field("alive", want.alive, got.alive);
      endfunction
   endclass

   logic clock;
   logic reset;

   east_req_if req_bus();
   east_rsp_if rsp_bus();
   east_csr_if csr_bus();

   encoder_angle_speed_tracker #(.WINDOW_LEN(WINDOW_LEN)) u_top (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   angle_speed_predictor tracker = new();

   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int cur_pos        = 0;
   int quiet_cycles   = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side back-pressure
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // observe every handshake on all three channels
   always @(posedge clock) begin
      tracker_result_t seen;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            tracker.apply_reg(csr_bus.index, csr_bus.data);
         if (req_bus.valid && req_bus.ready)
            tracker.add_request(req_bus.action, req_bus.position_count, req_bus.speed_count);
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.angle          = rsp_bus.angle;
            seen.speed          = rsp_bus.speed;
            seen.filtered_speed = rsp_bus.filtered_speed;
            seen.alive          = rsp_bus.alive;
            tracker.check_response(seen);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one input transaction, with random idle cycles ahead of it
   task automatic send(logic [ACTION_W-1:0] action, logic signed [COUNT_W-1:0] pos = '0,
                       logic signed [RAW_W-1:0] raw = '0);
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.action         <= action;
      req_bus.position_count <= pos;
      req_bus.speed_count    <= raw;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // stop sending and wait for every owed result
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.due_results.size() != 0) @(posedge clock);
   endtask

   task automatic put_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   // full register set, spare indexes first; only called with the block drained
   task automatic write_regs(logic [31:0] aps, logic [31:0] gain, logic [31:0] tmo,
                             logic [15:0] cmax, logic [15:0] cmin, logic rev);
      put_reg(CSR_SPARE_LO, $urandom);
      put_reg(CSR_SPARE_HI, $urandom);
      put_reg(CSR_ANGLE_PER_STEP, aps);
      put_reg(CSR_SPEED_GAIN, gain);
      put_reg(CSR_TIMEOUT_TICKS, tmo);
      put_reg(CSR_COUNT_MAX, {16'd0, cmax});
      put_reg(CSR_COUNT_MIN, {16'd0, cmin});
      put_reg(CSR_REVERSE, {31'd0, rev});
      csr_bus.valid <= 1'b0;
   endtask

   // random traffic: positions mostly walking a counter within its range, with speeds, ticks and the unused action
   task automatic run_random(int count);
      int                      pick, cmin, cmax, span, reach, stride, offs, burst;
      longint                  bound;
      logic signed [COUNT_W-1:0] pos16;
      logic signed [RAW_W-1:0] raw;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         cmin = tracker.count_min;
         cmax = tracker.count_max;
         if (pick < 45) begin
            span = cmax - cmin + 1;
            if (span > 1 && $urandom_range(99) < 70) begin
               reach   = (span > 6) ? span / 3 : 1;
               stride  = $urandom_range(2 * reach);
               stride -= reach;
               cur_pos = cmin + (((cur_pos - cmin + stride) % span) + span) % span;
            end else if ($urandom_range(1)) begin
               offs    = $urandom_range(3);
               cur_pos = $urandom_range(1) ? cmax - offs : cmin + offs;
            end else begin
               pos16   = $urandom;
               cur_pos = pos16;
            end
            send(ACTION_POSITION, cur_pos[15:0], $urandom);
         end else if (pick < 70) begin
            case ($urandom_range(3))
               0: begin
                  raw = $urandom_range(10000);
                  raw = raw - 5000;
               end
               1: raw = $urandom;
               2: begin
                  case ($urandom_range(4))
                     0: raw = 32'sh7FFF_FFFF;
                     1: raw = 32'sh8000_0000;
                     2: raw = '0;
                     3: raw = -1;
                     default: raw = 1;
                  endcase
               end
               default: begin
                  // around the point where the gained speed saturates
                  if (tracker.speed_gain == 0) begin
                     raw = $urandom;
                  end else begin
                     bound = 64'sh7FFF_FFFF / longint'({32'd0, tracker.speed_gain});
                     raw   = bound + $urandom_range(2) - 1;
                     if ($urandom_range(1)) raw = -raw;
                  end
               end
            endcase
            send(ACTION_SPEED, $urandom, raw);
         end else if (pick < 96) begin
            burst = 1;
            if (tracker.timeout_ticks <= 40 && $urandom_range(99) < 8)
               burst = tracker.timeout_ticks + 1 + $urandom_range(2);
            repeat (burst) send(ACTION_TICK, $urandom, $urandom);
            n += burst - 1;
         end else begin
            send(ACTION_NONE, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.action         <= ACTION_TICK;
      req_bus.position_count <= '0;
      req_bus.speed_count    <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.index          <= CSR_ANGLE_PER_STEP;
      csr_bus.data           <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed, register values from reset
      send(ACTION_TICK);
      send(ACTION_SPEED, '0, 32'sd100);
      send(ACTION_NONE, -16'sd1, -32'sd1);
      send(ACTION_POSITION, 16'sd0);
      send(ACTION_POSITION, 16'sh7FFF);
      send(ACTION_POSITION, 16'sh8000);
      send(ACTION_POSITION, 16'sh7FFF);
      send(ACTION_POSITION, 16'sd16383);
      send(ACTION_SPEED, '0, 32'sh7FFF_FFFF);
      send(ACTION_SPEED, '0, 32'sh8000_0000);
      send(ACTION_SPEED, '0, -32'sd1);
      send(ACTION_SPEED, '0, 32'sd1);
      send(ACTION_NONE, 16'sh7FFF, 32'sh7FFF_FFFF);
      send(ACTION_POSITION, 16'sh8000);

      // directed, largest scales, reversed, narrow counter and no timeout slack
      drain();
      write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 16'sd100, -16'sd100, 1'b1);
      send(ACTION_POSITION, 16'sd90);
      send(ACTION_POSITION, -16'sd95);
      send(ACTION_POSITION, 16'sd95);
      send(ACTION_SPEED, '0, -32'sd3);
      send(ACTION_TICK);
      send(ACTION_SPEED, '0, 32'sd5);
      send(ACTION_TICK);
      send(ACTION_POSITION, 16'sd7);
      send(ACTION_TICK);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 47; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 47; end
            default: begin send_gap_pct = 17; recv_stall_pct = 17; end
         endcase
         case (phase)
            0: write_regs($urandom, GAIN_RESET, TIMEOUT_RESET, CMAX_RESET, CMIN_RESET, 1'b0);
            1: write_regs('1, '1, '0, CMAX_RESET, CMIN_RESET, 1'b1);
            2: write_regs($urandom, $urandom_range(1 << 20), $urandom_range(12, 1),
                          16'sd1023, 16'sd0, 1'b0);
            3: write_regs('0, '0, '1, CMIN_RESET, CMAX_RESET, 1'b1);
            4: write_regs($urandom, $urandom, 32'd3, 16'sd99, -16'sd100, 1'b1);
            5: write_regs($urandom, $urandom, $urandom_range(30), $urandom, $urandom,
                          $urandom_range(1));
            6: write_regs(32'd1, 32'd1, 32'd5, 16'sd4095, 16'sd0, 1'b0);
            default: write_regs(APS_RESET, GAIN_RESET, $urandom_range(20, 2), CMAX_RESET,
                                CMIN_RESET, 1'b0);
         endcase
         run_random(PHASE_ITEMS / 2);
         // sender holds off until the block has nothing left in flight
         if (phase == 5) drain();
         run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/east_pkg.sv
sv/east_req_if.sv
sv/east_rsp_if.sv
sv/east_csr_if.sv
sv/east_ram.sv
sv/east_mean_div.sv
sv/encoder_angle_speed_tracker.sv
dv/tb.sv
